// ===== rtl/rrs_pkg.sv =====
// Shared types and constants of the ranging responder session block.
package rrs_pkg;

    // Session phase, also used as the action code of a result
    typedef enum logic [1:0] {
        PH_LISTEN_POLL  = 2'd0,
        PH_SEND_RESP    = 2'd1,
        PH_LISTEN_FINAL = 2'd2,
        PH_SEND_DONE    = 2'd3
    } phase_t;

    // Input item kinds
    localparam logic KIND_STEP  = 1'b0;
    localparam logic KIND_RESET = 1'b1;

    // Configuration register indexes
    localparam int CfgIndexBits = 3;
    localparam int CfgDataBits  = 8;
    typedef logic [CfgIndexBits-1:0] cfg_index_t;

    localparam cfg_index_t CFG_RETRY_LIMIT   = 3'd0;
    localparam cfg_index_t CFG_POLL_CODE     = 3'd1;
    localparam cfg_index_t CFG_RESPONSE_CODE = 3'd2;
    localparam cfg_index_t CFG_FINAL_CODE    = 3'd3;
    localparam cfg_index_t CFG_DONE_CODE     = 3'd4;

    // Field widths fixed by the interface
    localparam int TimeBits  = 40;
    localparam int CountBits = 4;
    localparam int ByteBits  = 8;

    // Register reset values
    localparam logic [CountBits-1:0] RETRY_LIMIT_RST   = 4'd3;
    localparam logic [ByteBits-1:0]  POLL_CODE_RST     = 8'hA1;
    localparam logic [ByteBits-1:0]  RESPONSE_CODE_RST = 8'hB2;
    localparam logic [ByteBits-1:0]  FINAL_CODE_RST    = 8'hA2;
    localparam logic [ByteBits-1:0]  DONE_CODE_RST     = 8'hB4;

endpackage

// ===== rtl/ranging_responder_session.sv =====
// Top level of the ranging responder session: phase sequencer and result register.
//
// Responder of a four-message two-way ranging session. Each input transaction
// reports the outcome of the action of the current phase (listen for poll, send
// response, listen for final, send done) or, with kind set, resets the session.
// Every transaction yields exactly one result transaction. The block takes one
// transaction per clock cycle while its output register is free: the phase, retry
// count and timestamp registers update at acceptance and the result lands in a
// single output register in the next cycle. The input side stays ready while the
// output register is empty or being drained in the same cycle. Configuration
// writes take effect at the next clock edge and must be done while idle.
// Timestamps are kept in STAMP_BITS bits and shown on 40-bit ports.
module ranging_responder_session
    import rrs_pkg::*;
#(
    parameter int STAMP_BITS = 40
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CfgIndexBits-1:0] cfg_index,
    input  logic [CfgDataBits-1:0]  cfg_data,

    // Input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic                  rx_ok,
    input  logic [ByteBits-1:0]   rx_first_byte,
    input  logic [TimeBits-1:0]   rx_time,
    input  logic                  tx_ok,
    input  logic [TimeBits-1:0]   tx_time,

    // Output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            action,
    output logic [ByteBits-1:0]   send_byte,
    output logic [1:0]            next_phase,
    output logic [CountBits-1:0]  retries_used,
    output logic [TimeBits-1:0]   poll_rx_time,
    output logic [TimeBits-1:0]   resp_tx_time,
    output logic [TimeBits-1:0]   final_rx_time,
    output logic                  session_done,
    output logic                  session_aborted
);

    typedef logic [STAMP_BITS-1:0] stamp_t;

    // Configuration registers
    logic [CountBits-1:0] retry_limit_reg;
    logic [ByteBits-1:0]  poll_code_reg;
    logic [ByteBits-1:0]  response_code_reg;
    logic [ByteBits-1:0]  final_code_reg;
    logic [ByteBits-1:0]  done_code_reg;

    // Session state
    phase_t               phase_reg, phase_next;
    logic [CountBits-1:0] retry_count_reg, retry_count_next;
    stamp_t               poll_stamp_reg, poll_stamp_next;
    stamp_t               resp_stamp_reg, resp_stamp_next;
    stamp_t               final_stamp_reg, final_stamp_next;

    // Result register
    logic                 out_valid_reg;
    phase_t               action_reg, action_next;
    logic [ByteBits-1:0]  send_byte_reg, send_byte_next;
    logic                 done_reg, done_next;
    logic                 aborted_reg, aborted_next;
    phase_t               next_phase_reg;
    logic [CountBits-1:0] retries_reg;
    stamp_t               poll_out_reg, resp_out_reg, final_out_reg;

    logic                 in_fire;
    logic                 out_free;

    // Handshake: accept while the result register is empty or draining
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = out_free;
    assign in_fire  = in_valid && out_free;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg   <= RETRY_LIMIT_RST;
            poll_code_reg     <= POLL_CODE_RST;
            response_code_reg <= RESPONSE_CODE_RST;
            final_code_reg    <= FINAL_CODE_RST;
            done_code_reg     <= DONE_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RETRY_LIMIT:   retry_limit_reg   <= cfg_data[CountBits-1:0];
                CFG_POLL_CODE:     poll_code_reg     <= cfg_data;
                CFG_RESPONSE_CODE: response_code_reg <= cfg_data;
                CFG_FINAL_CODE:    final_code_reg    <= cfg_data;
                CFG_DONE_CODE:     done_code_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Advance the session by one step
    always_comb
    begin
        phase_next       = phase_reg;
        retry_count_next = retry_count_reg;
        poll_stamp_next  = poll_stamp_reg;
        resp_stamp_next  = resp_stamp_reg;
        final_stamp_next = final_stamp_reg;
        action_next      = PH_LISTEN_POLL;
        send_byte_next   = '0;
        done_next        = 1'b0;
        aborted_next     = 1'b0;

        if (kind == KIND_RESET)
        begin
            phase_next       = PH_LISTEN_POLL;
            retry_count_next = '0;
            poll_stamp_next  = '0;
            resp_stamp_next  = '0;
            final_stamp_next = '0;
        end
        else
        begin
            action_next = phase_reg;
            unique case (phase_reg)
                PH_LISTEN_POLL:
                begin
                    if (rx_ok && rx_first_byte == poll_code_reg)
                    begin
                        poll_stamp_next = STAMP_BITS'(rx_time);
                        phase_next      = PH_SEND_RESP;
                    end
                end
                PH_SEND_RESP:
                begin
                    send_byte_next = response_code_reg;
                    if (tx_ok)
                    begin
                        resp_stamp_next = STAMP_BITS'(tx_time);
                        phase_next      = PH_LISTEN_FINAL;
                    end
                end
                PH_LISTEN_FINAL:
                begin
                    if (rx_ok && rx_first_byte == final_code_reg)
                    begin
                        final_stamp_next = STAMP_BITS'(rx_time);
                        phase_next       = PH_SEND_DONE;
                    end
                    else if (retry_count_reg < retry_limit_reg)
                    begin
                        // resend the response
                        retry_count_next = retry_count_reg + 1'b1;
                        phase_next       = PH_SEND_RESP;
                    end
                    else
                    begin
                        // retries used up: drop the session
                        retry_count_next = '0;
                        phase_next       = PH_LISTEN_POLL;
                        aborted_next     = 1'b1;
                    end
                end
                PH_SEND_DONE:
                begin
                    send_byte_next = done_code_reg;
                    phase_next     = PH_LISTEN_POLL;
                    done_next      = 1'b1;
                end
                default:
                begin
                    phase_next = PH_LISTEN_POLL;
                end
            endcase
        end
    end

    // Hold session state; update on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LISTEN_POLL;
            retry_count_reg <= '0;
            poll_stamp_reg  <= '0;
            resp_stamp_reg  <= '0;
            final_stamp_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg       <= phase_next;
            retry_count_reg <= retry_count_next;
            poll_stamp_reg  <= poll_stamp_next;
            resp_stamp_reg  <= resp_stamp_next;
            final_stamp_reg <= final_stamp_next;
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg     <= action_next;
            send_byte_reg  <= send_byte_next;
            next_phase_reg <= phase_next;
            retries_reg    <= retry_count_next;
            poll_out_reg   <= poll_stamp_next;
            resp_out_reg   <= resp_stamp_next;
            final_out_reg  <= final_stamp_next;
            done_reg       <= done_next;
            aborted_reg    <= aborted_next;
        end
    end

    // Drive the output ports
    assign out_valid       = out_valid_reg;
    assign action          = action_reg;
    assign send_byte       = send_byte_reg;
    assign next_phase      = next_phase_reg;
    assign retries_used    = retries_reg;
    assign poll_rx_time    = TimeBits'(poll_out_reg);
    assign resp_tx_time    = TimeBits'(resp_out_reg);
    assign final_rx_time   = TimeBits'(final_out_reg);
    assign session_done    = done_reg;
    assign session_aborted = aborted_reg;

endmodule

// ===== rtl/rrs_checker.sv =====
// Port-level assertions for the ranging responder session, bound to the top level.
module rrs_checker
    import rrs_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [1:0]              action,
    input logic [ByteBits-1:0]     send_byte,
    input logic [1:0]              next_phase,
    input logic [CountBits-1:0]    retries_used,
    input logic                    session_done,
    input logic                    session_aborted
);

    // Done closes the session from the send-done phase
    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && session_done) |->
            (action == PH_SEND_DONE && next_phase == PH_LISTEN_POLL && !session_aborted))
        else $error("session_done outside the closing step");

    // Abort only from listen-final, back to idle with a cleared counter
    a_abort_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && session_aborted) |->
            (action == PH_LISTEN_FINAL && next_phase == PH_LISTEN_POLL && retries_used == '0))
        else $error("abort result inconsistent");

    // Listen phases transmit nothing
    a_listen_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == PH_LISTEN_POLL || action == PH_LISTEN_FINAL)) |->
            (send_byte == '0 && !session_done))
        else $error("send_byte set in a listen phase");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(action) && $stable(next_phase) && $stable(retries_used)))
        else $error("stalled result changed");

endmodule

bind ranging_responder_session rrs_checker u_rrs_checker (.*);
